[src/longest_prefix_match_unit_defines.svh]
// Assertion macros shared by the route lookup checker.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define LPM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define LPM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lpm_pkg.sv]
// Shared types, constants and helpers for the longest prefix match unit.
// No dependencies.
package lpm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int CMDQ_DEPTH          = 2;
    localparam int COUNT_W             = 7;
    localparam int ADDR_W              = 3;
    localparam int INDEX_W             = 6;
    localparam int LEN_W               = 6;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // register index carried in paddr[2]
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic               is_lookup;
        logic               wr_ok;
        logic [INDEX_W-1:0] idx;
        logic [31:0]        pmask;
        logic [31:0]        mask;
        logic [LEN_W-1:0]   len;
        logic [31:0]        hop;
        logic [7:0]         port;
        logic [31:0]        dest;
    } cmd_t;

    // two-level count: nibble sums, then eight narrow adds
    function automatic logic [LEN_W-1:0] popcount32(input logic [31:0] v);
        logic [2:0]       nib [8];
        logic [LEN_W-1:0] sum;
        for (int j = 0; j < 8; j++) begin
            nib[j] = 3'(v[4*j]) + 3'(v[4*j+1]) + 3'(v[4*j+2]) + 3'(v[4*j+3]);
        end
        sum = '0;
        for (int j = 0; j < 8; j++) begin
            sum = sum + LEN_W'(nib[j]);
        end
        return sum;
    endfunction

endpackage

[src/longest_prefix_match_unit.sv]
// Longest prefix match route lookup. Every beat in gives exactly one beat out,
// in order. A write beat (func 0) stores prefix, mask, next hop and port at
// entry_index and returns an all-zero beat; slots at or past TABLE_DEPTH are
// dropped. A lookup beat (func 1) scans slots 0 .. entry_count-1 (entry_count
// saturates at TABLE_DEPTH) one slot per clock through the single read port of
// the route table; the longest matching mask wins, the lowest slot on a tie.
// A write or an empty-table lookup skips the scan. A two-beat command queue
// sits in front of the scanner, so new beats are taken while a lookup runs or
// a result waits to be popped. Slots must be written before a lookup scans
// them; the table has no reset. The user must write entry_count over the APB
// port at address 0 only while idle; the block does not enforce this.
module longest_prefix_match_unit #(
    parameter int TABLE_DEPTH = lpm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    // command side
    input  logic                        push,
    output logic                        full,
    input  logic                        func,
    input  logic [lpm_pkg::INDEX_W-1:0] entry_index,
    input  logic [31:0]                 entry_prefix,
    input  logic [31:0]                 entry_mask,
    input  logic [31:0]                 entry_next_hop,
    input  logic [7:0]                  entry_port,
    input  logic [31:0]                 dest_addr,

    // result side
    output logic                        empty,
    input  logic                        pop,
    output logic                        hit,
    output logic [31:0]                 route_next_hop,
    output logic [7:0]                  route_port,
    output logic [lpm_pkg::INDEX_W-1:0] matched_index,
    output logic [lpm_pkg::LEN_W-1:0]   prefix_length
);

    logic [lpm_pkg::COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic                        cfg_wr;
    logic                        cfg_sel;

    lpm_pkg::cmd_t front_cmd;
    lpm_pkg::cmd_t q_head;
    logic          q_empty;
    logic          q_pop;

    // APB: zero wait states, register index in paddr[2]
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == lpm_pkg::REG_ENTRY_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? 32'(entry_count_reg) : '0;

    assign entry_count_next = cfg_wr ? pwdata[lpm_pkg::COUNT_W-1:0] : entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    lpm_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .func           (func),
        .entry_index    (entry_index),
        .entry_prefix   (entry_prefix),
        .entry_mask     (entry_mask),
        .entry_next_hop (entry_next_hop),
        .entry_port     (entry_port),
        .dest_addr      (dest_addr),
        .cmd            (front_cmd)
    );

    lpm_cmd_fifo u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    lpm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .entry_count    (entry_count_reg),
        .q_head         (q_head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .hit            (hit),
        .route_next_hop (route_next_hop),
        .route_port     (route_port),
        .matched_index  (matched_index),
        .prefix_length  (prefix_length)
    );

endmodule

[src/lpm_front.sv]
// Front end: classifies an incoming beat into a command for the queue.
// Depends on lpm_pkg.
module lpm_front #(
    parameter int TABLE_DEPTH = lpm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                        func,
    input  logic [lpm_pkg::INDEX_W-1:0] entry_index,
    input  logic [31:0]                 entry_prefix,
    input  logic [31:0]                 entry_mask,
    input  logic [31:0]                 entry_next_hop,
    input  logic [7:0]                  entry_port,
    input  logic [31:0]                 dest_addr,
    output lpm_pkg::cmd_t               cmd
);

    always_comb
    begin
        cmd.is_lookup = (func == lpm_pkg::FUNC_LOOKUP);
        // slots at or past the table end are dropped
        cmd.wr_ok     = (32'(entry_index) < 32'(TABLE_DEPTH));
        cmd.idx       = entry_index;
        cmd.pmask     = entry_prefix & entry_mask;
        cmd.mask      = entry_mask;
        cmd.len       = lpm_pkg::popcount32(entry_mask);
        cmd.hop       = entry_next_hop;
        cmd.port      = entry_port;
        cmd.dest      = dest_addr;
    end

endmodule

[src/lpm_cmd_fifo.sv]
// Short command queue between front and back end.
// Depends on lpm_pkg.
module lpm_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  lpm_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output lpm_pkg::cmd_t rd_data,
    output logic          empty
);

    localparam int PTR_W = (lpm_pkg::CMDQ_DEPTH > 1) ? $clog2(lpm_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(lpm_pkg::CMDQ_DEPTH + 1);

    lpm_pkg::cmd_t    slot_reg [lpm_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(lpm_pkg::CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (32'(p) == lpm_pkg::CMDQ_DEPTH - 1)
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/lpm_back.sv]
// Back end: route table memory, sequential scan and result register.
// Depends on lpm_pkg.
module lpm_back #(
    parameter int TABLE_DEPTH = lpm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lpm_pkg::COUNT_W-1:0] entry_count,
    input  lpm_pkg::cmd_t               q_head,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic                        hit,
    output logic [31:0]                 route_next_hop,
    output logic [7:0]                  route_port,
    output logic [lpm_pkg::INDEX_W-1:0] matched_index,
    output logic [lpm_pkg::LEN_W-1:0]   prefix_length
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W = lpm_pkg::LEN_W;

    typedef struct packed {
        logic [31:0]      pmask;
        logic [31:0]      mask;
        logic [LEN_W-1:0] len;
        logic [31:0]      hop;
        logic [7:0]       port;
    } row_t;

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    row_t route_mem [TABLE_DEPTH];
    row_t rd_row_reg;
    row_t wr_row;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0] limit;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [31:0]      dest_reg, dest_next;
    logic             found_reg, found_next;
    logic [LEN_W-1:0] best_len_reg, best_len_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0]      best_hop_reg, best_hop_next;
    logic [7:0]       best_port_reg, best_port_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        hit_reg, hit_next;
    logic [31:0]                 hop_reg, hop_next;
    logic [7:0]                  port_reg, port_next;
    logic [lpm_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]            len_reg, len_next;

    logic             mem_we;
    logic             rd_en;
    logic             slot_free;
    logic             match;
    logic             scan_done;

    assign wr_row.pmask = q_head.pmask;
    assign wr_row.mask  = q_head.mask;
    assign wr_row.len   = q_head.len;
    assign wr_row.hop   = q_head.hop;
    assign wr_row.port  = q_head.port;

    // counts above the table size scan the whole table
    assign limit = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(entry_count);

    assign slot_free = !out_valid_reg || pop;
    assign rd_en     = (state_reg == S_SCAN) && (issue_reg != limit_reg);
    assign match     = ((rd_row_reg.mask & dest_reg) == rd_row_reg.pmask);
    assign scan_done = (issue_reg == limit_reg) && !cmp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        limit_next     = limit_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        dest_next      = dest_reg;
        found_next     = found_reg;
        best_len_next  = best_len_reg;
        best_idx_next  = best_idx_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        out_valid_next = out_valid_reg && !pop;
        hit_next       = hit_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.is_lookup && (limit != '0))
                    begin
                        q_pop      = 1'b1;
                        issue_next = '0;
                        limit_next = limit;
                        dest_next  = q_head.dest;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else if (slot_free)
                    begin
                        // table write, or lookup on an empty table: all-zero beat
                        q_pop          = 1'b1;
                        mem_we         = !q_head.is_lookup && q_head.wr_ok;
                        out_valid_next = 1'b1;
                        hit_next       = 1'b0;
                        hop_next       = '0;
                        port_next      = '0;
                        idx_next       = '0;
                        len_next       = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next     = issue_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                end
                // strict greater keeps the lowest slot on equal length
                if (cmp_valid_reg && match && (!found_reg || (rd_row_reg.len > best_len_reg)))
                begin
                    found_next     = 1'b1;
                    best_len_next  = rd_row_reg.len;
                    best_idx_next  = cmp_idx_reg;
                    best_hop_next  = rd_row_reg.hop;
                    best_port_next = rd_row_reg.port;
                end
                if (scan_done && slot_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = found_reg;
                    hop_next       = found_reg ? best_hop_reg : '0;
                    port_next      = found_reg ? best_port_reg : '0;
                    idx_next       = found_reg ? lpm_pkg::INDEX_W'(best_idx_reg) : '0;
                    len_next       = found_reg ? best_len_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg     <= issue_next;
        limit_reg     <= limit_next;
        cmp_idx_reg   <= cmp_idx_next;
        dest_reg      <= dest_next;
        best_len_reg  <= best_len_next;
        best_idx_reg  <= best_idx_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        hit_reg       <= hit_next;
        hop_reg       <= hop_next;
        port_reg      <= port_next;
        idx_reg       <= idx_next;
        len_reg       <= len_next;
    end

    // route table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            route_mem[IDX_W'(q_head.idx)] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= route_mem[issue_reg[IDX_W-1:0]];
        end
    end

    assign empty          = !out_valid_reg;
    assign hit            = hit_reg;
    assign route_next_hop = hop_reg;
    assign route_port     = port_reg;
    assign matched_index  = idx_reg;
    assign prefix_length  = len_reg;

endmodule

[src/lpm_checker.sv]
// Port-level checker for the longest prefix match unit, bound to the top.
// Depends on lpm_pkg and longest_prefix_match_unit_defines.svh.
`include "longest_prefix_match_unit_defines.svh"

module lpm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        pop,
    input logic                        empty,
    input logic                        hit,
    input logic [31:0]                 route_next_hop,
    input logic [7:0]                  route_port,
    input logic [lpm_pkg::INDEX_W-1:0] matched_index,
    input logic [lpm_pkg::LEN_W-1:0]   prefix_length
);

    localparam int RES_W = 1 + 32 + 8 + lpm_pkg::INDEX_W + lpm_pkg::LEN_W;

    // beats taken in but not yet popped
    logic [2:0] outstanding_reg, outstanding_next;
    logic       acc_in, acc_out;
    logic       miss_zero;
    logic       res_wait;
    logic [RES_W-1:0] res_bits;

    assign acc_in  = push && !full;
    assign acc_out = pop && !empty;

    assign miss_zero = (route_next_hop == 32'd0) && (route_port == 8'd0)
                       && (matched_index == '0) && (prefix_length == '0);
    assign res_wait  = !empty && !pop;
    assign res_bits  = {hit, route_next_hop, route_port, matched_index, prefix_length};

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (acc_in && !acc_out)
        begin
            outstanding_next = outstanding_reg + 3'd1;
        end
        else if (acc_out && !acc_in)
        begin
            outstanding_next = outstanding_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `LPM_ASSERT_IMPLY(a_no_orphan_result, !empty, outstanding_reg != 3'd0, "orphan result beat")
    `LPM_ASSERT_IMPLY(a_miss_is_zero, !empty && !hit, miss_zero, "miss beat not all zero")
    `LPM_ASSERT_IMPLY(a_len_range, !empty && hit, prefix_length <= 6'd32, "length above 32")
    `LPM_ASSERT_NEXT(a_result_holds, res_wait, !empty && $stable(res_bits), "held beat changed")

endmodule

bind longest_prefix_match_unit lpm_checker u_lpm_checker (.*);
